// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of the display controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("display controller assertion failed");

// Next-cycle implication, switched off while reset is high.
`define SSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("display controller assertion failed");

// Next-cycle implication that also holds through reset.
`define SSS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("display controller assertion failed");

`endif

// ===== rtl/sss_pkg.sv =====
// Shared types, codes, constants and the character decoder of the display controller.
`timescale 1ns / 1ps

package sss_pkg;

   localparam int BUFFER_CHARS_DEF = 16;
   localparam int DIGITS_DEF       = 4;

   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int DIGIT_W  = 3;
   localparam int SEG_W    = 7;
   localparam int BRIGHT_W = 4;
   // One bit wider than the brightness field: the slot counter stops at level + 1.
   localparam int SLOT_W   = BRIGHT_W + 1;

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_PUT   = 2'd1;
   localparam logic [OP_W-1:0] OP_ERASE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 4'd10;
   localparam logic [SEG_W-1:0]    SEG_BLANK    = 7'h00;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CH_E     = 8'h45;
   localparam logic [CHAR_W-1:0] CH_L     = 8'h4C;
   localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
   localparam logic [CHAR_W-1:0] CH_LC_N  = 8'h6E;
   localparam logic [CHAR_W-1:0] CH_LC_R  = 8'h72;
   localparam logic [CHAR_W-1:0] CH_LC_D  = 8'h64;
   localparam logic [CHAR_W-1:0] CH_LC_O  = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_LC_U  = 8'h75;
   localparam logic [CHAR_W-1:0] CH_LC_T  = 8'h74;

   localparam logic [SEG_W-1:0] DIGIT_PAT [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
   };

   // Write command from the control logic to the character store.
   typedef struct packed {
      logic put;
      logic erase;
      logic clear;
   } store_cmd_type;

   typedef struct packed {
      logic             known;
      logic [SEG_W-1:0] pattern;
   } glyph_type;

   function automatic glyph_type glyph_of(input logic [CHAR_W-1:0] code);
      glyph_type g;
      g.known   = 1'b1;
      g.pattern = SEG_BLANK;
      if (code >= CH_ZERO && code <= CH_NINE) begin
         // The low nibble of an ASCII digit is its value.
         g.pattern = DIGIT_PAT[code[3:0]];
      end else begin
         unique case (code)
            CH_MINUS: g.pattern = 7'h40;
            CH_A:     g.pattern = 7'h77;
            CH_E:     g.pattern = 7'h79;
            CH_L:     g.pattern = 7'h38;
            CH_P:     g.pattern = 7'h73;
            CH_LC_N:  g.pattern = 7'h54;
            CH_LC_R:  g.pattern = 7'h50;
            CH_LC_D:  g.pattern = 7'h5E;
            CH_LC_O:  g.pattern = 7'h5C;
            CH_LC_U:  g.pattern = 7'h1C;
            CH_LC_T:  g.pattern = 7'h78;
            default:  g.known   = 1'b0;
         endcase
      end
      return g;
   endfunction

endpackage

// ===== rtl/sss_char_store.sv =====
// Character store: pattern memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps

module sss_char_store #(
   parameter int BUFFER_CHARS = sss_pkg::BUFFER_CHARS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sss_pkg::store_cmd_type          cmd,
   input  logic [$clog2(BUFFER_CHARS)-1:0] wr_addr,
   input  logic [sss_pkg::SEG_W-1:0]       wr_pattern,
   input  logic                            rd_en,
   input  logic [$clog2(BUFFER_CHARS)-1:0] rd_addr,
   output logic [sss_pkg::SEG_W-1:0]       rd_pattern,
   output logic                            rd_valid
);

   logic [sss_pkg::SEG_W-1:0] mem [BUFFER_CHARS];
   logic [BUFFER_CHARS-1:0]   valid_ff;
   logic [BUFFER_CHARS-1:0]   valid_in;
   logic [sss_pkg::SEG_W-1:0] rd_pattern_ff;
   logic                      rd_valid_ff;

   // An entry that is not valid reads as blank, so erase and clear touch only the valid bits.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.put) begin
         valid_in[wr_addr] = 1'b1;
      end else if (cmd.erase) begin
         valid_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         mem[wr_addr] <= wr_pattern;
      end
   end

   // The read sees the write of the same cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_pattern_ff <= (cmd.put && wr_addr == rd_addr) ? wr_pattern : mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_in[rd_addr];
         end
      end
   end

   assign rd_pattern = rd_pattern_ff;
   assign rd_valid   = rd_valid_ff;

endmodule

// ===== rtl/sss_scan.sv =====
// Multiplex slot tracking, brightness blanking and the segment latch.
`timescale 1ns / 1ps

module sss_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick_en,
   input  logic [sss_pkg::DIGIT_W-1:0]  digit,
   input  logic [sss_pkg::SEG_W-1:0]    load_pattern,
   input  logic [sss_pkg::BRIGHT_W-1:0] bright_level,
   output logic [sss_pkg::SEG_W-1:0]    segments
);

   logic [sss_pkg::DIGIT_W-1:0] shown_ff, shown_in;
   logic [sss_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [sss_pkg::SEG_W-1:0]   latch_ff, latch_in;
   logic [sss_pkg::SLOT_W-1:0]  level_x;

   assign level_x = sss_pkg::SLOT_W'(bright_level);

   always_comb begin
      shown_in = shown_ff;
      slot_in  = slot_ff;
      latch_in = latch_ff;
      if (tick_en) begin
         if (digit == shown_ff && slot_ff != '0) begin
            // A level of zero leaves the digit lit for its whole slot.
            if (slot_ff < level_x) begin
               slot_in = slot_ff + 1'b1;
            end else if (slot_ff == level_x) begin
               latch_in = sss_pkg::SEG_BLANK;
               slot_in  = slot_ff + 1'b1;
            end
         end else begin
            shown_in = digit;
            latch_in = load_pattern;
            slot_in  = sss_pkg::SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_ff <= '0;
         slot_ff  <= '0;
         latch_ff <= sss_pkg::SEG_BLANK;
      end else begin
         shown_ff <= shown_in;
         slot_ff  <= slot_in;
         latch_ff <= latch_in;
      end
   end

   assign segments = latch_ff;

endmodule

// ===== rtl/seven_segment_scroll_display.sv =====
// Top level of the scrolling seven-segment display controller.
`timescale 1ns / 1ps

// Each request beat carries one operation: tick (follow the external multiplexer's
// active digit), put a character, erase the last character, or clear the store. Every
// beat yields exactly one response beat carrying the segment latch after the operation,
// bit 0 for segment a up to bit 6 for segment g. As a beat enters the input register,
// the character store is read for the digit it names; the beat executes from there once
// the response register is free or being emptied, and then the segment latch, which
// is also the response register, and the window state are updated. With the response
// side always ready, one beat is taken every cycle; the only thing that stops the
// request side is a response beat that the consumer has not yet taken. The store
// holds BUFFER_CHARS patterns with one valid bit each, so a clear resets only the valid
// bits and needs no sweep after reset. The window fills up to DIGITS places and then
// scrolls; once it cannot scroll any further, puts are dropped. Characters without a
// glyph still take a place and show blank. The brightness register gives the number of
// ticks a digit stays lit in its multiplex slot (zero keeps it lit throughout); it
// resets to ten and should be written only while no beat is in flight.
module seven_segment_scroll_display #(
   parameter int BUFFER_CHARS = sss_pkg::BUFFER_CHARS_DEF,
   parameter int DIGITS       = sss_pkg::DIGITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sss_pkg::OP_W-1:0]     req_operation,
   input  logic [sss_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [sss_pkg::DIGIT_W-1:0]  req_active_digit,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sss_pkg::SEG_W-1:0]    rsp_segments,
   input  logic                         csr_wr_en,
   input  logic [sss_pkg::BRIGHT_W-1:0] csr_wr_data
);

   localparam int AW  = $clog2(BUFFER_CHARS);
   // Wide enough for a window position plus a digit or DIGITS without overflow.
   localparam int SW  = AW + 1;
   localparam int FCW = $clog2(DIGITS + 1);

   localparam logic [SW-1:0]  BC_X     = SW'(BUFFER_CHARS);
   localparam logic [SW-1:0]  DIGITS_X = SW'(DIGITS);
   localparam logic [FCW-1:0] DIGITS_F = FCW'(DIGITS);

   // Input register.
   logic                        s1_vld_ff;
   logic [sss_pkg::OP_W-1:0]    s1_op_ff;
   logic [sss_pkg::CHAR_W-1:0]  s1_char_ff;
   logic [sss_pkg::DIGIT_W-1:0] s1_digit_ff;

   logic                         rsp_vld_ff;
   logic [sss_pkg::BRIGHT_W-1:0] bright_ff;

   // Window state.
   logic [AW-1:0]  ws_ff, ws_in;
   logic [FCW-1:0] fc_ff, fc_in;

   logic exec;
   logic accept;

   sss_pkg::store_cmd_type    cmd;
   sss_pkg::glyph_type        glyph;
   logic [SW-1:0]             ws_x, fc_x, dg_x, pos_x, wr_x, rd_x;
   logic                      rd_en;
   logic [sss_pkg::SEG_W-1:0] rd_pattern;
   logic                      rd_valid;
   logic [sss_pkg::SEG_W-1:0] load_pattern;
   logic                      tick_en;

   // The beat in the input register executes whenever the response register is free
   // or is being emptied in this cycle; the request side follows straight from that.
   assign exec      = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || exec;
   assign accept    = req_valid && req_ready;

   assign ws_x  = SW'(ws_ff);
   assign fc_x  = SW'(fc_ff);
   assign dg_x  = SW'(s1_digit_ff);
   assign glyph = sss_pkg::glyph_of(s1_char_ff);

   always_comb begin
      ws_in = ws_ff;
      fc_in = fc_ff;
      cmd   = '0;
      wr_x  = ws_x + fc_x;
      if (exec) begin
         unique case (s1_op_ff)
            sss_pkg::OP_TICK: begin
               // Ticks leave the store and the window alone.
            end
            sss_pkg::OP_PUT: begin
               if (ws_x + DIGITS_X < BC_X) begin
                  cmd.put = glyph.known && wr_x < BC_X;
                  if (fc_ff < DIGITS_F) begin
                     fc_in = fc_ff + 1'b1;
                  end else begin
                     ws_in = ws_ff + 1'b1;
                  end
               end
            end
            sss_pkg::OP_ERASE: begin
               if (ws_ff != '0) begin
                  // Scroll back and drop the character that falls off the right-hand end.
                  ws_in     = ws_ff - 1'b1;
                  wr_x      = ws_x - 1'b1 + fc_x;
                  cmd.erase = wr_x < BC_X;
               end else if (fc_ff != '0) begin
                  fc_in     = fc_ff - 1'b1;
                  wr_x      = fc_x - 1'b1;
                  cmd.erase = wr_x < BC_X;
               end
            end
            default: begin
               // Clear all.
               ws_in     = '0;
               fc_in     = '0;
               cmd.clear = 1'b1;
            end
         endcase
      end
   end

   // The store is read as the beat enters, at the window position that holds once
   // the beat ahead of it has executed.
   assign rd_x  = SW'(ws_in) + SW'(req_active_digit);
   assign rd_en = accept && rd_x < BC_X;

   sss_char_store #(
      .BUFFER_CHARS (BUFFER_CHARS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .wr_addr    (wr_x[AW-1:0]),
      .wr_pattern (glyph.pattern),
      .rd_en      (rd_en),
      .rd_addr    (rd_x[AW-1:0]),
      .rd_pattern (rd_pattern),
      .rd_valid   (rd_valid)
   );

   // A digit beyond the filled part of the window shows blank.
   assign pos_x        = ws_x + dg_x;
   assign load_pattern = (dg_x < fc_x && pos_x < BC_X && rd_valid) ? rd_pattern
                                                                   : sss_pkg::SEG_BLANK;
   assign tick_en      = exec && s1_op_ff == sss_pkg::OP_TICK;

   // The segment latch only changes on execution, so it doubles as the response register.
   sss_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .tick_en      (tick_en),
      .digit        (s1_digit_ff),
      .load_pattern (load_pattern),
      .bright_level (bright_ff),
      .segments     (rsp_segments)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         ws_ff      <= '0;
         fc_ff      <= '0;
         bright_ff  <= sss_pkg::BRIGHT_RESET;
      end else begin
         if (accept) begin
            s1_vld_ff <= 1'b1;
         end else if (exec) begin
            s1_vld_ff <= 1'b0;
         end
         if (exec) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
         ws_ff <= ws_in;
         fc_ff <= fc_in;
         if (csr_wr_en) begin
            bright_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_operation;
         s1_char_ff  <= req_char_code;
         s1_digit_ff <= req_active_digit;
      end
   end

   assign rsp_valid = rsp_vld_ff;

endmodule

// ===== rtl/sss_checker.sv =====
// Port-level checker of the display controller and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sss_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [sss_pkg::SEG_W-1:0] rsp_segments
);

   // Reset leaves the block empty and ready for a request beat.
   `SSS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, req_ready && !rsp_valid)

   // The request side is held off only by a response beat that is not being taken.
   `SSS_ASSERT_NOW(a_no_bubble, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // An accepted request beat is followed by a response on offer.
   `SSS_ASSERT_NOW(a_latency, clock, reset, req_valid && req_ready, ##2 rsp_valid)

   // A stalled response beat stays on offer and unchanged.
   `SSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_segments))

endmodule

bind seven_segment_scroll_display sss_checker u_sss_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_segments (rsp_segments)
);
